FILE: sv/tba_pkg.sv
// tba_pkg: shared types and constants for the timer bank time advance block
// action codes, field widths and the interrupt command and status words
// no dependencies
package tba_pkg;

  localparam int TIME_W      = 64;
  localparam int ACT_W       = 3;
  localparam int IDX_W       = 5;
  localparam int FIRED_OUT_W = 8;
  localparam int ALLOC_OUT_W = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADVANCE   = 3'd0,
    ACT_SET_TIMER = 3'd1,
    ACT_ALLOCATE  = 3'd2,
    ACT_RELEASE   = 3'd3,
    ACT_IRQ_EN    = 3'd4,
    ACT_IRQ_FLAG  = 3'd5,
    ACT_IRQ_GLOB  = 3'd6
  } action_t;

  typedef struct packed {
    logic             en_we;
    logic             flag_we;
    logic             master_we;
    logic [IDX_W-1:0] sel;
    logic             val;
  } irq_cmd_t;

  typedef struct packed {
    logic             pending;
    logic [IDX_W-1:0] index;
  } irq_stat_t;

endpackage

FILE: sv/tba_ram.sv
// tba_ram: generic one-write one-read memory with registered read data
// used for timer deadlines and reload periods, no dependencies
module tba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/tba_irq.sv
// tba_irq: interrupt enable, flag and global enable registers
// reports lowest enabled+flagged line if master set, uses tba_pkg
module tba_irq
  import tba_pkg::*;
#(
  parameter int NUM_IRQS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  irq_cmd_t  cmd,
  output irq_stat_t stat
);

  localparam int CMP_W = 7;
  localparam int IW    = (NUM_IRQS > 1) ? $clog2(NUM_IRQS) : 1;

  logic [NUM_IRQS-1:0] en_r, en_nxt;
  logic [NUM_IRQS-1:0] flag_r, flag_nxt;
  logic                master_r, master_nxt;
  logic [NUM_IRQS-1:0] active;
  logic [IW-1:0]       low_idx;
  logic                any_active;
  logic [IW+IDX_W-1:0] low_ext;

  always_comb begin
    en_nxt     = en_r;
    flag_nxt   = flag_r;
    master_nxt = master_r;
    for (int i = 0; i < NUM_IRQS; i++) begin
      if (CMP_W'(i) == CMP_W'(cmd.sel)) begin
        if (cmd.en_we) begin
          en_nxt[i] = cmd.val;
        end
        if (cmd.flag_we) begin
          flag_nxt[i] = cmd.val;
        end
      end
    end
    if (cmd.master_we) begin
      master_nxt = cmd.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= '0;
      flag_r   <= '0;
      master_r <= 1'b0;
    end else begin
      en_r     <= en_nxt;
      flag_r   <= flag_nxt;
      master_r <= master_nxt;
    end
  end

  assign active = en_r & flag_r;

  always_comb begin
    any_active = 1'b0;
    low_idx    = '0;
    for (int i = NUM_IRQS - 1; i >= 0; i--) begin
      if (active[i]) begin
        any_active = 1'b1;
        low_idx    = IW'(i);
      end
    end
  end

  assign low_ext      = {{IDX_W{1'b0}}, low_idx};
  assign stat.pending = master_r && any_active;
  assign stat.index   = stat.pending ? low_ext[IDX_W-1:0] : '0;

endmodule

FILE: sv/timer_bank_time_advance.sv
// timer_bank_time_advance: timer bank with 64-bit global time advance
// sequencer, shared 64-bit comparator and reload adder; uses tba_pkg, tba_ram, tba_irq
//
// One word in, one word out. An advance runs one sequencer: it scans the timer
// deadlines one per cycle through the deadline memory's read port to find the
// step, uses the same comparator to cap it at the target and raise the global
// time, then scans again to fire and reload timers. Every other action goes
// from the execute state straight to the done state. The input is ready again
// the cycle after the result is loaded into the output register; a waiting
// result does not block the next word, which then holds in the sequencer until
// the output register frees. Writing start_time loads the global time at once
// and is always ready.
module timer_bank_time_advance
  import tba_pkg::*;
#(
  parameter int NUM_TIMERS = 8,
  parameter int NUM_IRQS   = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACT_W-1:0]       in_action,
  input  logic [TIME_W-1:0]      in_target_time,
  input  logic [TIME_W-1:0]      in_external_bound,
  input  logic [IDX_W-1:0]       in_index,
  input  logic                   in_enable_value,
  input  logic [TIME_W-1:0]      in_timeout_at,
  input  logic [TIME_W-1:0]      in_period,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [TIME_W-1:0]      out_global_time,
  output logic [TIME_W-1:0]      out_step_time,
  output logic [FIRED_OUT_W-1:0] out_fired_mask,
  output logic [ALLOC_OUT_W-1:0] out_alloc_index,
  output logic                   out_alloc_ok,
  output logic                   out_irq_pending,
  output logic [IDX_W-1:0]       out_irq_index,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [TIME_W-1:0]      cfg_start_time
);

  localparam int AW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int CMP_W = 7;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_MIN   = 7'b0000100,
    S_CAP   = 7'b0001000,
    S_RAISE = 7'b0010000,
    S_FIRE  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ACT_W-1:0]  act_r;
  logic [TIME_W-1:0] target_r, bound_r, timeout_r, period_r;
  logic [IDX_W-1:0]  idx_r;
  logic              val_r;

  logic [TIME_W-1:0]     time_now_r, time_now_nxt;
  logic [TIME_W-1:0]     step_r, step_nxt;
  logic [NUM_TIMERS-1:0] on_r, on_nxt;
  logic [NUM_TIMERS-1:0] taken_r, taken_nxt;
  logic [NUM_TIMERS-1:0] mask_r, mask_nxt;
  logic [AW-1:0]         alloc_idx_r, alloc_idx_nxt;
  logic                  alloc_ok_r, alloc_ok_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;

  logic                   out_valid_r;
  logic [TIME_W-1:0]      out_time_r, out_step_r;
  logic [FIRED_OUT_W-1:0] out_fired_r;
  logic [ALLOC_OUT_W-1:0] out_alloc_idx_r;
  logic                   out_alloc_ok_r, out_pend_r;
  logic [IDX_W-1:0]       out_irq_idx_r;

  logic [TIME_W-1:0] cmp_a, cmp_b;
  logic              cmp_lt, cmp_eq;

  logic              dl_we, rl_we;
  logic [AW-1:0]     dl_waddr, rd_addr;
  logic [TIME_W-1:0] dl_wdata, dl_q, rl_q, reload_sum;

  logic [CMP_W-1:0]  idx_ext;
  logic [AW-1:0]     idx_addr;
  logic              idx_in_range;
  logic              free_found;
  logic [AW-1:0]     free_slot;
  logic              load_out;

  logic [NUM_TIMERS+FIRED_OUT_W-1:0] mask_ext;
  logic [AW+ALLOC_OUT_W-1:0]         alloc_ext;

  irq_cmd_t  irq_cmd;
  irq_stat_t irq_stat;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign idx_ext      = CMP_W'(idx_r);
  assign idx_addr     = idx_ext[AW-1:0];
  assign idx_in_range = idx_ext < CMP_W'(NUM_TIMERS);

  // shared comparator and reload adder
  assign cmp_lt     = cmp_a < cmp_b;
  assign cmp_eq     = cmp_a == cmp_b;
  assign reload_sum = dl_q + rl_q;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!taken_r[i]) begin
        free_found = 1'b1;
        free_slot  = AW'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    time_now_nxt  = time_now_r;
    step_nxt      = step_r;
    on_nxt        = on_r;
    taken_nxt     = taken_r;
    mask_nxt      = mask_r;
    alloc_idx_nxt = alloc_idx_r;
    alloc_ok_nxt  = alloc_ok_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    rd_addr       = cnt_r[AW-1:0];
    cmp_a         = dl_q;
    cmp_b         = step_r;
    dl_we         = 1'b0;
    rl_we         = 1'b0;
    dl_waddr      = idx_addr;
    dl_wdata      = timeout_r;
    irq_cmd       = '0;
    irq_cmd.sel   = idx_r;
    irq_cmd.val   = val_r;
    load_out      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        step_nxt      = '0;
        mask_nxt      = '0;
        alloc_idx_nxt = '0;
        alloc_ok_nxt  = 1'b0;
        cnt_nxt       = '0;
        state_nxt     = S_DONE;
        case (act_r)
          ACT_ADVANCE: begin
            step_nxt  = bound_r;
            state_nxt = S_MIN;
          end
          ACT_SET_TIMER: begin
            if (idx_in_range) begin
              dl_we            = 1'b1;
              rl_we            = 1'b1;
              on_nxt[idx_addr] = val_r;
            end
          end
          ACT_ALLOCATE: begin
            if (free_found) begin
              taken_nxt[free_slot] = 1'b1;
              alloc_idx_nxt        = free_slot;
              alloc_ok_nxt         = 1'b1;
            end
          end
          ACT_RELEASE: begin
            if (idx_in_range) begin
              taken_nxt[idx_addr] = 1'b0;
            end
          end
          ACT_IRQ_EN: begin
            irq_cmd.en_we = 1'b1;
          end
          ACT_IRQ_FLAG: begin
            irq_cmd.flag_we = 1'b1;
          end
          ACT_IRQ_GLOB: begin
            irq_cmd.master_we = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_MIN: begin
        if (cnt_r != CNT_W'(NUM_TIMERS)) begin
          cnt_nxt    = cnt_r + CNT_W'(1);
          rd_idx_nxt = cnt_r[AW-1:0];
          rd_vld_nxt = 1'b1;
        end else begin
          state_nxt = S_CAP;
        end
        if (rd_vld_r && on_r[rd_idx_r] && cmp_lt) begin
          step_nxt = dl_q;
        end
      end
      S_CAP: begin
        cmp_a = target_r;
        if (cmp_lt) begin
          step_nxt = target_r;
        end
        state_nxt = S_RAISE;
      end
      S_RAISE: begin
        cmp_a = time_now_r;
        if (cmp_lt) begin
          time_now_nxt = step_r;
        end
        cnt_nxt   = '0;
        state_nxt = S_FIRE;
      end
      S_FIRE: begin
        if (cnt_r != CNT_W'(NUM_TIMERS)) begin
          cnt_nxt    = cnt_r + CNT_W'(1);
          rd_idx_nxt = cnt_r[AW-1:0];
          rd_vld_nxt = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
        if (rd_vld_r && on_r[rd_idx_r] && (cmp_lt || cmp_eq)) begin
          mask_nxt[rd_idx_r] = 1'b1;
          if (rl_q != '0) begin
            dl_we    = 1'b1;
            dl_waddr = rd_idx_r;
            dl_wdata = reload_sum;
          end else begin
            on_nxt[rd_idx_r] = 1'b0;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      time_now_nxt = cfg_start_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      time_now_r <= '0;
      on_r       <= '0;
      taken_r    <= '0;
      rd_vld_r   <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      time_now_r <= time_now_nxt;
      on_r       <= on_nxt;
      taken_r    <= taken_nxt;
      rd_vld_r   <= rd_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    mask_r      <= mask_nxt;
    alloc_idx_r <= alloc_idx_nxt;
    alloc_ok_r  <= alloc_ok_nxt;
    rd_idx_r    <= rd_idx_nxt;
    if (in_valid && in_ready) begin
      act_r     <= in_action;
      target_r  <= in_target_time;
      bound_r   <= in_external_bound;
      idx_r     <= in_index;
      val_r     <= in_enable_value;
      timeout_r <= in_timeout_at;
      period_r  <= in_period;
    end
  end

  // output word register
  assign mask_ext  = {{FIRED_OUT_W{1'b0}}, mask_r};
  assign alloc_ext = {{ALLOC_OUT_W{1'b0}}, alloc_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_time_r      <= time_now_r;
      out_step_r      <= step_r;
      out_fired_r     <= mask_ext[FIRED_OUT_W-1:0];
      out_alloc_idx_r <= alloc_ext[ALLOC_OUT_W-1:0];
      out_alloc_ok_r  <= alloc_ok_r;
      out_pend_r      <= irq_stat.pending;
      out_irq_idx_r   <= irq_stat.index;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_global_time = out_time_r;
  assign out_step_time   = out_step_r;
  assign out_fired_mask  = out_fired_r;
  assign out_alloc_index = out_alloc_idx_r;
  assign out_alloc_ok    = out_alloc_ok_r;
  assign out_irq_pending = out_pend_r;
  assign out_irq_index   = out_irq_idx_r;

  tba_ram #(
    .WIDTH(TIME_W),
    .DEPTH(NUM_TIMERS)
  ) u_deadline_ram (
    .clk  (clk),
    .we   (dl_we),
    .waddr(dl_waddr),
    .wdata(dl_wdata),
    .raddr(rd_addr),
    .rdata(dl_q)
  );

  tba_ram #(
    .WIDTH(TIME_W),
    .DEPTH(NUM_TIMERS)
  ) u_reload_ram (
    .clk  (clk),
    .we   (rl_we),
    .waddr(idx_addr),
    .wdata(period_r),
    .raddr(rd_addr),
    .rdata(rl_q)
  );

  tba_irq #(
    .NUM_IRQS(NUM_IRQS)
  ) u_irq (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (irq_cmd),
    .stat (irq_stat)
  );

endmodule

FILE: sim/tb_top.sv
// tb_top: self-checking bench for timer_bank_time_advance, directed cases then random mixes
// predicts every status word from its own copy of the timer bank and checks it field by field
// depends on tba_pkg and the timer_bank_time_advance rtl only
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tba_pkg::*;

  localparam int NUM_TIMERS = 8;
  localparam int NUM_IRQS = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam logic [TIME_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [IDX_W-1:0]  index;
    logic              en;
    logic [TIME_W-1:0] timeout;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] target;
    logic [TIME_W-1:0] bound;
  } bank_cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0]      global_time;
    logic [TIME_W-1:0]      step_time;
    logic [FIRED_OUT_W-1:0] fired;
    logic [ALLOC_OUT_W-1:0] alloc_index;
    logic                   alloc_ok;
    logic                   irq_pending;
    logic [IDX_W-1:0]       irq_index;
  } bank_status_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [ACT_W-1:0]       in_action;
  logic [TIME_W-1:0]      in_target_time;
  logic [TIME_W-1:0]      in_external_bound;
  logic [IDX_W-1:0]       in_index;
  logic                   in_enable_value;
  logic [TIME_W-1:0]      in_timeout_at;
  logic [TIME_W-1:0]      in_period;
  logic                   out_valid;
  logic                   out_ready;
  logic [TIME_W-1:0]      out_global_time;
  logic [TIME_W-1:0]      out_step_time;
  logic [FIRED_OUT_W-1:0] out_fired_mask;
  logic [ALLOC_OUT_W-1:0] out_alloc_index;
  logic                   out_alloc_ok;
  logic                   out_irq_pending;
  logic [IDX_W-1:0]       out_irq_index;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [TIME_W-1:0]      cfg_start_time;

  // shadow copy of the timer bank
  logic [TIME_W-1:0] bank_time;
  logic              tmr_on       [NUM_TIMERS];
  logic              tmr_taken    [NUM_TIMERS];
  logic [TIME_W-1:0] tmr_deadline [NUM_TIMERS];
  logic [TIME_W-1:0] tmr_period   [NUM_TIMERS];
  logic [NUM_IRQS-1:0] irq_en_bits;
  logic [NUM_IRQS-1:0] irq_flag_bits;
  logic                irq_master;

  bank_status_t status_fifo[$];
  bank_status_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int fail_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int fire_count = 0;
  int cfg_writes = 0;

  timer_bank_time_advance #(
    .NUM_TIMERS(NUM_TIMERS),
    .NUM_IRQS  (NUM_IRQS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_target_time   (in_target_time),
    .in_external_bound(in_external_bound),
    .in_index         (in_index),
    .in_enable_value  (in_enable_value),
    .in_timeout_at    (in_timeout_at),
    .in_period        (in_period),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_global_time  (out_global_time),
    .out_step_time    (out_step_time),
    .out_fired_mask   (out_fired_mask),
    .out_alloc_index  (out_alloc_index),
    .out_alloc_ok     (out_alloc_ok),
    .out_irq_pending  (out_irq_pending),
    .out_irq_index    (out_irq_index),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_start_time   (cfg_start_time)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("cycle limit of %0d reached with %0d results outstanding",
             CYCLE_LIMIT, status_fifo.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bank_cmd_t cmd(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] index,
                                    input logic en, input logic [TIME_W-1:0] timeout,
                                    input logic [TIME_W-1:0] period,
                                    input logic [TIME_W-1:0] target,
                                    input logic [TIME_W-1:0] bound);
    bank_cmd_t c;
    c.act = act;
    c.index = index;
    c.en = en;
    c.timeout = timeout;
    c.period = period;
    c.target = target;
    c.bound = bound;
    return c;
  endfunction

  // applies one word to the shadow bank and returns the status it must report
  function automatic bank_status_t compute_status(input bank_cmd_t c);
    bank_status_t r;
    logic [TIME_W-1:0] step;
    logic [NUM_IRQS-1:0] active;
    int i;
    r = '0;
    case (c.act)
      ACT_ADVANCE: begin
        step = c.bound;
        for (i = 0; i < NUM_TIMERS; i++)
          if (tmr_on[i] && tmr_deadline[i] < step) step = tmr_deadline[i];
        if (step > c.target) step = c.target;
        if (step > bank_time) bank_time = step;
        for (i = 0; i < NUM_TIMERS; i++) begin
          if (tmr_on[i] && tmr_deadline[i] <= step) begin
            if (tmr_period[i] != 0) tmr_deadline[i] = tmr_deadline[i] + tmr_period[i];
            else tmr_on[i] = 1'b0;
            r.fired[i] = 1'b1;
          end
        end
        r.step_time = step;
      end
      ACT_SET_TIMER: begin
        if (c.index < NUM_TIMERS) begin
          tmr_on[c.index] = c.en;
          tmr_deadline[c.index] = c.timeout;
          tmr_period[c.index] = c.period;
        end
      end
      ACT_ALLOCATE: begin
        for (i = 0; i < NUM_TIMERS; i++) begin
          if (!tmr_taken[i] && !r.alloc_ok) begin
            tmr_taken[i] = 1'b1;
            r.alloc_index = i[ALLOC_OUT_W-1:0];
            r.alloc_ok = 1'b1;
          end
        end
      end
      ACT_RELEASE: begin
        if (c.index < NUM_TIMERS) tmr_taken[c.index] = 1'b0;
      end
      ACT_IRQ_EN: begin
        if (c.index < NUM_IRQS) irq_en_bits[c.index] = c.en;
      end
      ACT_IRQ_FLAG: begin
        if (c.index < NUM_IRQS) irq_flag_bits[c.index] = c.en;
      end
      ACT_IRQ_GLOB: begin
        irq_master = c.en;
      end
      default: begin
      end
    endcase
    active = irq_en_bits & irq_flag_bits;
    if (irq_master) begin
      for (i = 0; i < NUM_IRQS; i++) begin
        if (active[i] && !r.irq_pending) begin
          r.irq_pending = 1'b1;
          r.irq_index = i[IDX_W-1:0];
        end
      end
    end
    r.global_time = bank_time;
    return r;
  endfunction

  task automatic send_word(input bank_cmd_t c);
    bank_status_t s;
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(30, 1);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= c.act;
    in_target_time <= c.target;
    in_external_bound <= c.bound;
    in_index <= c.index;
    in_enable_value <= c.en;
    in_timeout_at <= c.timeout;
    in_period <= c.period;
    do @(posedge clk); while (!in_ready);
    s = compute_status(c);
    fire_count += $countones(s.fired);
    status_fifo.push_back(s);
    words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_fifo.size() != 0) @(posedge clk);
  endtask

  task automatic write_start_time(input logic [TIME_W-1:0] t0);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_start_time <= t0;
    do @(posedge clk); while (!cfg_ready);
    bank_time = t0;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_alloc_release();
    int n;
    for (n = 0; n <= NUM_TIMERS; n++) send_word(cmd(ACT_ALLOCATE, 5'd0, 1'b0, 0, 0, 0, 0));
    send_word(cmd(ACT_RELEASE, 5'd3, 1'b0, 0, 0, 0, 0));
    send_word(cmd(ACT_RELEASE, 5'd13, 1'b0, 0, 0, 0, 0));
    send_word(cmd(ACT_ALLOCATE, 5'd31, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
  endtask

  task automatic test_timer_advance();
    send_word(cmd(ACT_SET_TIMER, 5'd0, 1'b1, 64'd100, 64'd0, 0, 0));
    send_word(cmd(ACT_SET_TIMER, 5'd1, 1'b1, 64'd50, 64'd30, 0, 0));
    send_word(cmd(ACT_SET_TIMER, 5'd12, 1'b1, 64'd5, 64'd0, 0, 0));
    send_word(cmd(ACT_ADVANCE, 5'd0, 1'b0, 0, 0, 64'd1000, ALL_ONES));
    send_word(cmd(ACT_ADVANCE, 5'd0, 1'b0, 0, 0, 64'd40, ALL_ONES));
    send_word(cmd(ACT_ADVANCE, 5'd0, 1'b0, 0, 0, 64'd1000, 64'd20));
    send_word(cmd(ACT_ADVANCE, 5'd0, 1'b0, 0, 0, 64'd500, ALL_ONES));
  endtask

  task automatic test_irq_status();
    send_word(cmd(ACT_IRQ_EN, 5'd31, 1'b1, 0, 0, 0, 0));
    send_word(cmd(ACT_IRQ_FLAG, 5'd31, 1'b1, 0, 0, 0, 0));
    send_word(cmd(ACT_IRQ_GLOB, 5'd0, 1'b1, 0, 0, 0, 0));
    send_word(cmd(ACT_IRQ_FLAG, 5'd0, 1'b1, 0, 0, 0, 0));
    send_word(cmd(ACT_IRQ_EN, 5'd0, 1'b1, 0, 0, 0, 0));
    send_word(cmd(ACT_UNUSED, 5'd31, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
  endtask

  // deadlines near the top of the time range, reload wraps around zero
  task automatic test_time_extremes();
    write_start_time(ALL_ONES - 64'd10);
    send_word(cmd(ACT_SET_TIMER, 5'd0, 1'b0, 0, 0, 0, 0));
    send_word(cmd(ACT_SET_TIMER, 5'd1, 1'b0, 0, 0, 0, 0));
    send_word(cmd(ACT_SET_TIMER, 5'd2, 1'b1, ALL_ONES - 64'd5, ALL_ONES, 0, 0));
    send_word(cmd(ACT_ADVANCE, 5'd0, 1'b0, 0, 0, ALL_ONES, ALL_ONES));
    write_start_time(ALL_ONES);
    send_word(cmd(ACT_ADVANCE, 5'd0, 1'b0, 0, 0, ALL_ONES, ALL_ONES));
  endtask

  task automatic test_output_backpressure();
    int n;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    for (n = 0; n < 12; n++)
      send_word(cmd(n[0] ? ACT_ALLOCATE : ACT_IRQ_FLAG, n[4:0], n[1], rand64(), rand64(),
                    rand64(), rand64()));
    drain_results();
  endtask

  task automatic test_random_mix(input logic [TIME_W-1:0] t0, input int idle_pct,
                                 input int stall_pct, input int count);
    bank_cmd_t c;
    int n;
    int roll;
    int pick;
    write_start_time(t0);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      c = cmd(ACT_UNUSED, IDX_W'($urandom), 1'($urandom), rand64(), rand64(), rand64(),
              rand64());
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      if (roll < 35) begin
        c.act = ACT_ADVANCE;
        if (pick < 92) c.target = bank_time + TIME_W'($urandom_range(400));
        if (pick < 45) c.bound = ALL_ONES;
        else if (pick < 88) c.bound = bank_time + TIME_W'($urandom_range(400));
      end else if (roll < 57) begin
        c.act = ACT_SET_TIMER;
        if (pick < 88) c.index = IDX_W'($urandom_range(NUM_TIMERS - 1));
        c.en = ($urandom_range(99) < 80);
        if (pick < 80) c.timeout = bank_time + TIME_W'($urandom_range(300));
        else if (pick < 88) c.timeout = bank_time - TIME_W'($urandom_range(50));
        pick = $urandom_range(99);
        if (pick < 35) c.period = '0;
        else if (pick < 85) c.period = TIME_W'($urandom_range(150, 1));
      end else if (roll < 67) begin
        c.act = ACT_ALLOCATE;
      end else if (roll < 75) begin
        c.act = ACT_RELEASE;
      end else if (roll < 84) begin
        c.act = ACT_IRQ_EN;
      end else if (roll < 93) begin
        c.act = ACT_IRQ_FLAG;
      end else if (roll < 97) begin
        c.act = ACT_IRQ_GLOB;
      end
      send_word(c);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (status_fifo.size() == 0) begin
        $error("status word with none outstanding: global_time %0h", out_global_time);
        fail_count++;
      end else begin
        want = status_fifo.pop_front();
        results_checked++;
        if (out_global_time !== want.global_time) begin
          $error("global_time: expected %0h, got %0h", want.global_time, out_global_time);
          fail_count++;
        end
        if (out_step_time !== want.step_time) begin
          $error("step_time: expected %0h, got %0h", want.step_time, out_step_time);
          fail_count++;
        end
        if (out_fired_mask !== want.fired) begin
          $error("fired_mask: expected %0h, got %0h", want.fired, out_fired_mask);
          fail_count++;
        end
        if (out_alloc_index !== want.alloc_index) begin
          $error("alloc_index: expected %0d, got %0d", want.alloc_index, out_alloc_index);
          fail_count++;
        end
        if (out_alloc_ok !== want.alloc_ok) begin
          $error("alloc_ok: expected %0d, got %0d", want.alloc_ok, out_alloc_ok);
          fail_count++;
        end
        if (out_irq_pending !== want.irq_pending) begin
          $error("irq_pending: expected %0d, got %0d", want.irq_pending, out_irq_pending);
          fail_count++;
        end
        if (out_irq_index !== want.irq_index) begin
          $error("irq_index: expected %0d, got %0d", want.irq_index, out_irq_index);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_ADVANCE;
    in_target_time = '0;
    in_external_bound = '0;
    in_index = '0;
    in_enable_value = 1'b0;
    in_timeout_at = '0;
    in_period = '0;
    cfg_valid = 1'b0;
    cfg_start_time = '0;
    bank_time = '0;
    for (i = 0; i < NUM_TIMERS; i++) begin
      tmr_on[i] = 1'b0;
      tmr_taken[i] = 1'b0;
      tmr_deadline[i] = '0;
      tmr_period[i] = '0;
    end
    irq_en_bits = '0;
    irq_flag_bits = '0;
    irq_master = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_alloc_release();
    test_timer_advance();
    test_irq_status();
    test_time_extremes();
    test_random_mix(64'd0, 0, 0, 360);
    test_random_mix(rand64(), 68, 0, 360);
    test_output_backpressure();
    test_random_mix(64'hFFFF_FFFF_FFFF_0000, 0, 68, 360);
    test_random_mix(64'd5000, 11, 11, 360);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d words sent, %0d status words checked, %0d timer fires, %0d start_time writes",
             words_sent, results_checked, fire_count, cfg_writes);
    $display("mixes: no idling, sender gaps, receiver stalls, both, and a long output hold");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
